// File: design/mouse_packet_stepper_drive_defines.svh
// Assertion macros shared by the mouse packet stepper drive RTL.
// No dependencies; included by modules that carry assertions.
`ifndef MOUSE_PACKET_STEPPER_DRIVE_DEFINES_SVH
`define MOUSE_PACKET_STEPPER_DRIVE_DEFINES_SVH

// Clocked check, masked while reset is asserted.
`define MPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds through reset.
`define MPS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: design/mps_pkg.sv
// Types and constants for the mouse packet stepper drive.
// No dependencies; imported by mps_axis and mouse_packet_stepper_drive.
package mps_pkg;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

  // Byte slots within a movement packet
  localparam logic [1:0] POS_STATUS = 2'd0;
  localparam logic [1:0] POS_XDELTA = 2'd1;
  localparam logic [1:0] POS_YDELTA = 2'd2;

  // Per-axis control for one request
  typedef struct packed {
    logic tick;    // step toward the sign of the pending count
    logic add_en;  // add a packet delta into the pending count
  } axis_ctl_t;

  // One-hot coil drive for a 2-bit phase
  function automatic logic [3:0] coil_onehot(input logic [1:0] phase);
    logic [3:0] coil;
    coil = 4'b0000;
    coil[phase] = 1'b1;
    return coil;
  endfunction

endpackage

// File: design/mouse_packet_stepper_drive.sv
// Mouse packet stepper drive: packet assembly, step counters, result register.
// Depends on mps_pkg, mps_axis and mouse_packet_stepper_drive_defines.svh.
//
// Usage:
//   in_*  : one request per handshake. in_cmd = byte selects a received mouse
//           byte in in_byte_value, in_cmd = tick advances both stepper axes.
//   cfg_* : writes reporting_enable (bit cfg_reporting_enable); cfg_ready is
//           always high. While it is 0 received bytes are dropped.
//   out_* : one result per request: coil drive, inverted status byte and
//           the signed pending step counts after that request.
// Latency: a result is valid in the cycle after its request is accepted.
// Throughput: one request per cycle while out_ready is high, set by the single
//   output register; next state is computed in one pass of adders and muxes.
// Stall: while out_valid is high and out_ready low, in_ready drops and the
//   result holds; as soon as the result is taken a new request is accepted
//   in the same cycle.
// Reset (rst_n low, synchronous): counts, phases, packet bytes and byte
//   position go to zero, reporting is disabled, no result is pending.
module mouse_packet_stepper_drive (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_cmd,
  input  logic [7:0]        in_byte_value,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_reporting_enable,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_coil_pattern,
  output logic [7:0]        out_status_lights,
  output logic signed [7:0] out_x_pending,
  output logic signed [7:0] out_y_pending
);
  import mps_pkg::*;

  `include "mouse_packet_stepper_drive_defines.svh"

  logic              report_en_r;
  logic [7:0]        status_byte_r, status_byte_nxt;
  logic [7:0]        xdelta_byte_r, xdelta_byte_nxt;  // byte 2 is used on arrival
  logic [1:0]        byte_pos_r, byte_pos_nxt;
  logic [7:0]        x_count_r, x_count_nxt;
  logic [7:0]        y_count_r, y_count_nxt;
  logic [1:0]        x_phase_r, x_phase_nxt;
  logic [1:0]        y_phase_r, y_phase_nxt;
  logic              out_valid_r;
  logic [7:0]        coil_r;
  logic [7:0]        status_out_r;
  logic [7:0]        x_out_r, y_out_r;
  logic              in_fire;
  axis_ctl_t         x_ctl, y_ctl;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    logic [1:0] pos;
    logic       take_byte;
    pos             = (byte_pos_r > POS_YDELTA) ? POS_STATUS : byte_pos_r;
    take_byte       = (in_cmd == CMD_BYTE) && report_en_r;
    status_byte_nxt = status_byte_r;
    xdelta_byte_nxt = xdelta_byte_r;
    byte_pos_nxt    = byte_pos_r;
    x_ctl           = '0;
    y_ctl           = '0;
    if (take_byte) begin
      unique case (pos)
        POS_STATUS: begin
          status_byte_nxt = in_byte_value;
          byte_pos_nxt    = POS_XDELTA;
        end
        POS_XDELTA: begin
          xdelta_byte_nxt = in_byte_value;
          byte_pos_nxt    = POS_YDELTA;
        end
        default: begin
          x_ctl.add_en = 1'b1;
          y_ctl.add_en = 1'b1;
          byte_pos_nxt = POS_STATUS;
        end
      endcase
    end
    if (in_cmd == CMD_TICK) begin
      x_ctl.tick = 1'b1;
      y_ctl.tick = 1'b1;
    end
  end

  mps_axis u_x_axis (
    .ctl       (x_ctl),
    .add_value (xdelta_byte_r),
    .count     (x_count_r),
    .phase     (x_phase_r),
    .count_nxt (x_count_nxt),
    .phase_nxt (x_phase_nxt)
  );

  mps_axis u_y_axis (
    .ctl       (y_ctl),
    .add_value (in_byte_value),
    .count     (y_count_r),
    .phase     (y_phase_r),
    .count_nxt (y_count_nxt),
    .phase_nxt (y_phase_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      report_en_r   <= 1'b0;
      status_byte_r <= 8'd0;
      xdelta_byte_r <= 8'd0;
      byte_pos_r    <= POS_STATUS;
      x_count_r     <= 8'd0;
      y_count_r     <= 8'd0;
      x_phase_r     <= 2'd0;
      y_phase_r     <= 2'd0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        report_en_r <= cfg_reporting_enable;
      end
      if (in_fire) begin
        status_byte_r <= status_byte_nxt;
        xdelta_byte_r <= xdelta_byte_nxt;
        byte_pos_r    <= byte_pos_nxt;
        x_count_r     <= x_count_nxt;
        y_count_r     <= y_count_nxt;
        x_phase_r     <= x_phase_nxt;
        y_phase_r     <= y_phase_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload, loaded only on an accepted request
  always_ff @(posedge clk) begin
    if (in_fire) begin
      coil_r       <= {coil_onehot(y_phase_nxt), coil_onehot(x_phase_nxt)};
      status_out_r <= ~status_byte_nxt;
      x_out_r      <= x_count_nxt;
      y_out_r      <= y_count_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_coil_pattern  = coil_r;
  assign out_status_lights = status_out_r;
  assign out_x_pending     = x_out_r;
  assign out_y_pending     = y_out_r;

  `MPS_ASSERT(a_result_follows_request, in_fire |=> out_valid_r, "no result after request")
  `MPS_ASSERT(a_byte_pos_range, byte_pos_r != 2'd3, "packet byte position out of range")
  `MPS_ASSERT(a_coil_onehot, out_valid_r |-> ($onehot(coil_r[3:0]) && $onehot(coil_r[7:4])), "coil drive not one-hot per axis")
  `MPS_ASSERT(a_byte_no_step, (in_fire && (in_cmd == CMD_BYTE)) |=> ($stable(x_phase_r) && $stable(y_phase_r)), "byte request moved a phase")
  `MPS_ASSERT(a_disabled_byte_ignored, (in_fire && (in_cmd == CMD_BYTE) && !report_en_r) |=> ($stable(x_count_r) && $stable(byte_pos_r)), "byte taken while reporting off")
  `MPS_ASSERT_RST(a_reset_clears_result, !rst_n |=> !out_valid_r, "result valid after reset")

endmodule

// File: design/mps_axis.sv
// Next-state logic for one stepper axis: pending count and coil phase.
// Depends on mps_pkg (axis_ctl_t).
module mps_axis (
  input  mps_pkg::axis_ctl_t ctl,
  input  logic [7:0]         add_value,
  input  logic [7:0]         count,
  input  logic [1:0]         phase,
  output logic [7:0]         count_nxt,
  output logic [1:0]         phase_nxt
);
  import mps_pkg::*;

  always_comb begin
    count_nxt = count;
    phase_nxt = phase;
    if (ctl.add_en) begin
      count_nxt = count + add_value;  // wraps mod 256
    end else if (ctl.tick && (count != 8'd0)) begin
      if (count[7]) begin
        count_nxt = count + 8'd1;
        phase_nxt = phase - 2'd1;
      end else begin
        count_nxt = count - 8'd1;
        phase_nxt = phase + 2'd1;
      end
    end
  end

endmodule

// File: tb/testbench.sv
// Self-checking testbench for mouse_packet_stepper_drive.
// Depends on mps_pkg and the RTL; drives requests and checks every result
// against an in-bench model of packet assembly, pending counts and phases.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mps_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  typedef struct {
    cmd_t       cmd;
    logic [7:0] value;
  } drive_req_t;

  typedef struct {
    logic [7:0]        coil_pattern;
    logic [7:0]        status_lights;
    logic signed [7:0] x_pending;
    logic signed [7:0] y_pending;
  } drive_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  cmd_t              in_cmd = CMD_BYTE;
  logic [7:0]        in_byte_value = 8'h00;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_reporting_enable = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [7:0]        out_coil_pattern;
  logic [7:0]        out_status_lights;
  logic signed [7:0] out_x_pending;
  logic signed [7:0] out_y_pending;

  mouse_packet_stepper_drive uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_cmd               (in_cmd),
    .in_byte_value        (in_byte_value),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_reporting_enable (cfg_reporting_enable),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_coil_pattern     (out_coil_pattern),
    .out_status_lights    (out_status_lights),
    .out_x_pending        (out_x_pending),
    .out_y_pending        (out_y_pending)
  );

  always #10 clk = ~clk;

  // Model state
  logic              reporting_on = 1'b0;
  logic [7:0]        packet_buf [3] = '{8'h00, 8'h00, 8'h00};
  logic [1:0]        packet_slot = POS_STATUS;
  logic signed [7:0] x_steps = '0;
  logic signed [7:0] y_steps = '0;
  logic [1:0]        x_ph = 2'd0;
  logic [1:0]        y_ph = 2'd0;

  drive_req_t    pending_reqs [$];
  drive_result_t results_due [$];

  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int mismatches = 0;
  int requests_done = 0;
  int results_seen = 0;
  int packets_done = 0;
  int quiet_cycles = 0;

  function automatic void step_toward_zero(inout logic signed [7:0] cnt,
                                           inout logic [1:0] ph);
    if (cnt < 0) begin
      ph  = ph - 2'd1;
      cnt = cnt + 8'sd1;
    end else if (cnt != 0) begin
      ph  = ph + 2'd1;
      cnt = cnt - 8'sd1;
    end
  endfunction

  function automatic drive_result_t predict_drive_step(cmd_t cmd, logic [7:0] value);
    drive_result_t r;
    if (cmd == CMD_BYTE) begin
      if (reporting_on) begin
        packet_buf[packet_slot] = value;
        if (packet_slot == POS_YDELTA) begin
          packet_slot = POS_STATUS;
          x_steps = x_steps + packet_buf[POS_XDELTA];
          y_steps = y_steps + packet_buf[POS_YDELTA];
          packets_done++;
        end else begin
          packet_slot = packet_slot + 2'd1;
        end
      end
    end else begin
      step_toward_zero(x_steps, x_ph);
      step_toward_zero(y_steps, y_ph);
    end
    r.coil_pattern  = (8'd1 << x_ph) | (8'd16 << y_ph);
    r.status_lights = ~packet_buf[POS_STATUS];
    r.x_pending     = x_steps;
    r.y_pending     = y_steps;
    return r;
  endfunction

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  // Request driver
  always @(posedge clk) begin : request_drive
    drive_req_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        results_due.push_back(predict_drive_step(in_cmd, in_byte_value));
        requests_done++;
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          req = pending_reqs.pop_front();
          in_valid      <= 1'b1;
          in_cmd        <= req.cmd;
          in_byte_value <= req.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin : result_check
    drive_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (results_due.size() == 0) begin
          $error("result with no request outstanding: coil %02h status %02h x %0d y %0d",
                 out_coil_pattern, out_status_lights, out_x_pending, out_y_pending);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          check_field("coil_pattern", want.coil_pattern, out_coil_pattern);
          check_field("status_lights", want.status_lights, out_status_lights);
          check_field("x_pending", want.x_pending, out_x_pending);
          check_field("y_pending", want.y_pending, out_y_pending);
        end
      end
      out_ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
    $display("mouse_packet_stepper_drive regression: fail");
    $finish;
  end

  task automatic push_req(input cmd_t cmd, input logic [7:0] value);
    drive_req_t req;
    req.cmd   = cmd;
    req.value = value;
    pending_reqs.push_back(req);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || results_due.size() != 0);
  endtask

  task automatic write_reporting(input logic enable);
    @(posedge clk);
    cfg_valid            <= 1'b1;
    cfg_reporting_enable <= enable;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid    <= 1'b0;
    reporting_on = enable;
    @(negedge clk);
  endtask

  // Mostly small deltas so ticks can drain the counts; some full-range.
  function automatic logic [7:0] random_delta();
    if ($urandom_range(99) < 70)
      return 8'($urandom_range(16)) - 8'd8;
    return 8'($urandom_range(255));
  endfunction

  // Packets with ticks woven in, tick bursts, and stray bytes that shift packet alignment.
  task automatic queue_random_traffic(input int n_items);
    int queued;
    int burst;
    queued = 0;
    while (queued < n_items) begin
      case ($urandom_range(9)) inside
        0: begin
          push_req(CMD_BYTE, 8'($urandom_range(255)));
          queued++;
        end
        [1:4]: begin
          push_req(CMD_BYTE, 8'($urandom_range(255)));
          if ($urandom_range(4) == 0) push_req(CMD_TICK, 8'($urandom_range(255)));
          push_req(CMD_BYTE, random_delta());
          if ($urandom_range(4) == 0) push_req(CMD_TICK, 8'($urandom_range(255)));
          push_req(CMD_BYTE, random_delta());
          queued += 3;
        end
        default: begin
          burst = $urandom_range(1, 8);
          repeat (burst) push_req(CMD_TICK, 8'($urandom_range(255)));
          queued += burst;
        end
      endcase
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reporting off after reset: bytes dropped, ticks with zero counts idle
    push_req(CMD_BYTE, 8'hAA);
    push_req(CMD_TICK, 8'h00);
    push_req(CMD_BYTE, 8'hFF);
    wait_drained();
    write_reporting(1'b1);
    // Extreme deltas, then stepping below phase zero
    push_req(CMD_BYTE, 8'hFF);
    push_req(CMD_BYTE, 8'h7F);
    push_req(CMD_BYTE, 8'h80);
    push_req(CMD_TICK, 8'hFF);
    push_req(CMD_TICK, 8'h00);
    // Counter wraps: 125 + 127 and -126 + -1, then -127 + -128
    push_req(CMD_BYTE, 8'h00);
    push_req(CMD_BYTE, 8'h7F);
    push_req(CMD_BYTE, 8'hFF);
    push_req(CMD_BYTE, 8'h3C);
    push_req(CMD_BYTE, 8'h00);
    push_req(CMD_BYTE, 8'h80);
    push_req(CMD_TICK, 8'h00);
    push_req(CMD_TICK, 8'h00);
    push_req(CMD_TICK, 8'h00);
    // Ticks between the bytes of one packet
    push_req(CMD_BYTE, 8'h5A);
    push_req(CMD_TICK, 8'h00);
    push_req(CMD_BYTE, 8'h01);
    push_req(CMD_TICK, 8'h00);
    push_req(CMD_BYTE, 8'h00);
    push_req(CMD_TICK, 8'h00);
    wait_drained();

    write_reporting(1'b1);
    queue_random_traffic(250);
    wait_drained();

    in_idle_pct = 69;
    write_reporting(1'b1);
    queue_random_traffic(200);
    wait_drained();

    in_idle_pct   = 0;
    out_stall_pct = 69;
    queue_random_traffic(200);
    wait_drained();

    // Reporting off with counts likely pending: bytes must change nothing
    in_idle_pct   = 26;
    out_stall_pct = 26;
    write_reporting(1'b0);
    queue_random_traffic(60);
    wait_drained();

    write_reporting(1'b1);
    queue_random_traffic(100);
    wait_drained();
    queue_random_traffic(80);
    wait_drained();
    write_reporting(1'b0);

    repeat (4) @(posedge clk);
    $display("Covered %0d requests (%0d full movement packets), %0d results checked,",
             requests_done, packets_done, results_seen);
    $display("across idle/stall mixes and reporting toggled on and off.");
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("mouse_packet_stepper_drive regression: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, results_due.size());
      $display("mouse_packet_stepper_drive regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/mps_pkg.sv
design/mps_axis.sv
design/mouse_packet_stepper_drive.sv
tb/testbench.sv
